[rtl/msq_pkg.sv]
// shared types and constants of the midi step sequencer
`default_nettype none

package msq_pkg;

    // sequencer geometry
    localparam int NUM_STEPS = 8;
    localparam int POS_W     = $clog2(NUM_STEPS + 1);
    localparam int IDX_W     = $clog2(NUM_STEPS);

    // reset values
    localparam logic [6:0] NOTE_RESET = 7'd60;
    localparam logic [7:0] TPB_RESET  = 8'd2;

    // one item can cause this many messages at most
    localparam int MAX_MSGS = 3;
    localparam int CNT_W    = $clog2(MAX_MSGS + 1);

    // entries in the queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_MUTE   = 2'd1,
        REQ_POT    = 2'd2,
        REQ_SELECT = 2'd3
    } req_t;

    // one midi message, velocity fixed and not carried
    typedef struct packed {
        logic       note_on;
        logic [6:0] note_number;
        logic       led_update;
        logic [7:0] led_pattern;
    } msg_t;

    // all messages caused by one item
    typedef struct packed {
        msg_t [MAX_MSGS-1:0] msgs;
        logic [CNT_W-1:0]    count;
    } entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

[rtl/msq_front.sv]
// front part: accepts items, keeps the sequencer state, builds message entries
`default_nettype none

module msq_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic [2:0]         button_code,
    input  wire logic [7:0]         pot_sample,
    input  wire msq_pkg::q_stat_t   qstat,
    output logic                    push,
    output msq_pkg::entry_t         push_entry
);
    import msq_pkg::*;

    // sequencer state
    logic [7:0]           tpb_reg;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]           div_reg, div_next;
    logic [IDX_W-1:0]     sel_reg, sel_next;
    logic [NUM_STEPS-1:0] muted_reg, muted_next;

    // note store with valid bits and registered reads at current and previous step
    logic [6:0]           note_mem [NUM_STEPS];
    logic [NUM_STEPS-1:0] note_vld_reg;
    logic [6:0]           cur_note_reg, prev_note_reg;
    logic                 note_we;
    logic [6:0]           note_wdata;
    logic [IDX_W-1:0]     rd_cur, rd_prev, cur_idx_now;

    logic                 accept, pos_valid, beat, cur_muted;
    logic [7:0]           div_inc, pattern;
    logic [3:0]           tog;
    msg_t                 off_cur;
    entry_t               entry;

    function automatic logic [IDX_W-1:0] step_idx(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] t;
        t = (p == '0) ? '0 : p - 1'b1;
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] c);
        return (c == '0) ? IDX_W'(NUM_STEPS - 1) : c - 1'b1;
    endfunction

    function automatic logic [6:0] note_read(input logic [IDX_W-1:0] a,
                                             input logic [NUM_STEPS-1:0] vld,
                                             input logic [6:0] data);
        return vld[a] ? data : NOTE_RESET;
    endfunction

    assign req_ready   = !qstat.full;
    assign accept      = req_valid && req_ready;
    assign pos_valid   = (pos_reg != '0);
    assign cur_idx_now = step_idx(pos_reg);
    assign cur_muted   = muted_reg[cur_idx_now];
    assign div_inc     = div_reg + 8'd1;
    assign beat        = (div_inc >= tpb_reg);
    assign tog         = 4'd7 - {1'b0, button_code};

    // led pattern for the current step
    always_comb
    begin
        pattern = 8'h00;
        if (!cur_muted && (int'(cur_idx_now) < 8))
            pattern = 8'h80 >> cur_idx_now;
    end

    // note-off for the current step
    always_comb
    begin
        off_cur             = '0;
        off_cur.note_number = cur_note_reg;
    end

    // classify the item and work out state and messages
    always_comb
    begin
        pos_next   = pos_reg;
        div_next   = div_reg;
        sel_next   = sel_reg;
        muted_next = muted_reg;
        note_we    = 1'b0;
        note_wdata = pot_sample[7:1];
        entry      = '0;
        if (accept)
        begin
            case (req_type)
                REQ_TICK:
                begin
                    if (pos_valid)
                    begin
                        entry.msgs[0] = off_cur;
                        entry.count   = CNT_W'(1);
                    end
                    div_next = div_inc;
                    if (beat)
                    begin
                        div_next = 8'd0;
                        if (pos_valid)
                        begin
                            entry.msgs[1].note_number = prev_note_reg;
                            entry.msgs[2].note_on     = !cur_muted;
                            entry.msgs[2].note_number = cur_note_reg;
                            entry.msgs[2].led_update  = 1'b1;
                            entry.msgs[2].led_pattern = pattern;
                            entry.count               = CNT_W'(3);
                        end
                        pos_next = (pos_reg < POS_W'(NUM_STEPS)) ? pos_reg + 1'b1
                                                                 : POS_W'(1);
                    end
                end
                REQ_MUTE:
                begin
                    if (int'(tog) < NUM_STEPS)
                        muted_next[IDX_W'(tog)] = !muted_reg[IDX_W'(tog)];
                end
                REQ_POT:
                begin
                    if (pos_valid)
                    begin
                        entry.msgs[0] = off_cur;
                        entry.count   = CNT_W'(1);
                    end
                    note_we = 1'b1;
                end
                REQ_SELECT:
                begin
                    if (pos_valid)
                    begin
                        entry.msgs[0] = off_cur;
                        entry.count   = CNT_W'(1);
                    end
                    sel_next = (sel_reg == IDX_W'(NUM_STEPS - 1)) ? '0 : sel_reg + 1'b1;
                end
                default:
                begin
                    entry = '0;
                end
            endcase
        end
    end

    assign push       = accept && (entry.count != '0);
    assign push_entry = entry;

    // read addresses follow the next step position
    assign rd_cur  = step_idx(pos_next);
    assign rd_prev = prev_idx(rd_cur);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpb_reg      <= TPB_RESET;
            pos_reg      <= '0;
            div_reg      <= 8'd0;
            sel_reg      <= '0;
            muted_reg    <= '0;
            note_vld_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                tpb_reg <= cfg_wr_data;
            pos_reg   <= pos_next;
            div_reg   <= div_next;
            sel_reg   <= sel_next;
            muted_reg <= muted_next;
            if (note_we)
                note_vld_reg[sel_reg] <= 1'b1;
        end
    end

    // note memory, write-first registered reads
    always_ff @(posedge clk)
    begin
        if (note_we)
            note_mem[sel_reg] <= note_wdata;
        if (note_we && (sel_reg == rd_cur))
            cur_note_reg <= note_wdata;
        else
            cur_note_reg <= note_read(rd_cur, note_vld_reg, note_mem[rd_cur]);
        if (note_we && (sel_reg == rd_prev))
            prev_note_reg <= note_wdata;
        else
            prev_note_reg <= note_read(rd_prev, note_vld_reg, note_mem[rd_prev]);
    end

`ifndef SYNTHESIS
    logic [6:0] cur_note_chk;
    assign cur_note_chk = note_read(cur_idx_now, note_vld_reg, note_mem[cur_idx_now]);

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) <= NUM_STEPS)
        else $error("step position out of range");

    a_cur_note: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid |-> (cur_note_reg == cur_note_chk))
        else $error("current note cache stale");

    a_beat_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_TICK) && beat) |=> (div_reg == 8'd0))
        else $error("divider not cleared on beat");
`endif

endmodule

`default_nettype wire

[rtl/msq_queue.sv]
// short queue of message entries between front and back
`default_nettype none

module msq_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire msq_pkg::entry_t   push_entry,
    input  wire logic              pop,
    output msq_pkg::entry_t        head,
    output msq_pkg::q_stat_t       qstat
);
    import msq_pkg::*;

    entry_t              store [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign head        = store[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_entry.count != '0))
        else $error("entry without messages queued");
`endif

endmodule

`default_nettype wire

[rtl/msq_back.sv]
// back part: sends the messages of each entry through an output register
`default_nettype none

module msq_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msq_pkg::entry_t   head,
    input  wire msq_pkg::q_stat_t  qstat,
    output logic                   pop,
    output logic                   msg_valid,
    input  wire logic              msg_ready,
    output logic                   note_on,
    output logic [6:0]             note_number,
    output logic                   led_update,
    output logic [7:0]             led_pattern,
    output logic                   last
);
    import msq_pkg::*;

    logic [CNT_W-1:0] idx_reg;
    logic             valid_reg;
    msg_t             msg_reg;
    logic             last_reg;
    logic             load, is_last;

    assign load    = !qstat.empty && (!valid_reg || msg_ready);
    assign is_last = (idx_reg == head.count - 1'b1);
    assign pop     = load && is_last;

    // message index within the head entry and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
            if (load)
                valid_reg <= 1'b1;
            else if (msg_ready)
                valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            msg_reg  <= head.msgs[idx_reg[1:0]];
            last_reg <= is_last;
        end
    end

    assign msg_valid   = valid_reg;
    assign note_on     = msg_reg.note_on;
    assign note_number = msg_reg.note_number;
    assign led_update  = msg_reg.led_update;
    assign led_pattern = msg_reg.led_pattern;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_idx_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> (idx_reg < head.count))
        else $error("message index past entry");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> (idx_reg == '0))
        else $error("message index left over");

    a_led_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !msg_reg.led_update) |-> (msg_reg.led_pattern == 8'h00))
        else $error("led pattern without update");
`endif

endmodule

`default_nettype wire

[rtl/midi_step_sequencer.sv]
// top level of the eight-step midi note sequencer
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_type, button_code, pot_sample
//  msg      out        msg_valid/msg_ready    note_on, note_number, led_update,
//                                             led_pattern, last
//  cfg      in         cfg_wr_en              cfg_wr_data (ticks_per_beat)
//
// an item is taken whenever req_ready is high; its zero to three messages leave one a cycle
// through the output register while msg_ready stays high
// a two-entry queue lets the front keep taking items while the back drains
// req_ready drops only when the queue is full; a stalled msg channel fills it
// reset clears step position, divider, mutes, pot selection and note valid bits
// at once; notes read as 60 until a pot sample writes them
`default_nettype none

module midi_step_sequencer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire logic [1:0] req_type,
    input  wire logic [2:0] button_code,
    input  wire logic [7:0] pot_sample,
    output logic            msg_valid,
    input  wire logic       msg_ready,
    output logic            note_on,
    output logic [6:0]      note_number,
    output logic            led_update,
    output logic [7:0]      led_pattern,
    output logic            last
);
    import msq_pkg::*;

    q_stat_t qstat;
    entry_t  push_entry, head;
    logic    push, pop;

    // front: state and classification
    msq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .button_code (button_code),
        .pot_sample  (pot_sample),
        .qstat       (qstat),
        .push        (push),
        .push_entry  (push_entry)
    );

    // entry queue
    msq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    // back: message output
    msq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .note_on     (note_on),
        .note_number (note_number),
        .led_update  (led_update),
        .led_pattern (led_pattern),
        .last        (last)
    );

endmodule

`default_nettype wire

[sim/sequencer_msg_checker.sv]
// checker for the midi step sequencer: predicts the messages of every item and compares them
`timescale 1ns / 1ps

module sequencer_msg_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic [1:0] req_type,
    input  logic [2:0] button_code,
    input  logic [7:0] pot_sample,
    input  logic       msg_valid,
    input  logic       msg_ready,
    input  logic       note_on,
    input  logic [6:0] note_number,
    input  logic       led_update,
    input  logic [7:0] led_pattern,
    input  logic       last,
    output int         mismatches,
    output int         pending,
    output int         checked
);
    import msq_pkg::*;

    // one predicted message plus its end-of-item mark
    typedef struct packed {
        msg_t body;
        logic last;
    } exp_msg_t;

    // shadow copy of the sequencer state
    logic [POS_W-1:0] cur_step;
    logic [7:0]       beat_count;
    logic [7:0]       beat_len;
    logic [6:0]       step_note [NUM_STEPS];
    logic [NUM_STEPS-1:0] step_mute;
    int               pot_sel;

    exp_msg_t expected_msgs [$];
    exp_msg_t head;

    function automatic exp_msg_t make_msg(input logic on, input logic [6:0] note,
                                          input logic led, input logic [7:0] pattern);
        exp_msg_t m;
        m.body.note_on     = on;
        m.body.note_number = note;
        m.body.led_update  = led;
        m.body.led_pattern = led ? pattern : 8'h00;
        m.last             = 1'b0;
        return m;
    endfunction

    // work out the messages of one item and update the shadow state
    task automatic predict_request(input req_t rt, input logic [2:0] code,
                                   input logic [7:0] sample);
        exp_msg_t burst [$];
        exp_msg_t m;
        bit       live;
        bit       muted;
        int       cur_idx;
        int       prev_idx;
        int       btn_step;
        logic [7:0] pattern;

        live = (cur_step >= 1) && (cur_step <= NUM_STEPS);
        case (rt)
            REQ_TICK:
            begin
                if (live)
                    burst.push_back(make_msg(1'b0, step_note[cur_step - 1], 1'b0, 8'h00));
                beat_count = beat_count + 8'd1;
                if (beat_count >= beat_len)
                begin
                    beat_count = 8'd0;
                    if (live)
                    begin
                        cur_idx  = cur_step - 1;
                        prev_idx = (cur_idx == 0) ? NUM_STEPS - 1 : cur_idx - 1;
                        muted    = step_mute[cur_idx];
                        pattern  = (!muted && cur_idx < 8) ? (8'h80 >> cur_idx) : 8'h00;
                        burst.push_back(make_msg(1'b0, step_note[prev_idx], 1'b0, 8'h00));
                        burst.push_back(make_msg(!muted, step_note[cur_idx], 1'b1, pattern));
                    end
                    cur_step = (cur_step < NUM_STEPS) ? cur_step + 1'b1 : POS_W'(1);
                end
            end
            REQ_MUTE:
            begin
                // button code counts steps down from the last one
                btn_step = 8 - int'(code);
                if (btn_step >= 1 && btn_step <= NUM_STEPS)
                    step_mute[btn_step - 1] = ~step_mute[btn_step - 1];
            end
            REQ_POT:
            begin
                if (live)
                    burst.push_back(make_msg(1'b0, step_note[cur_step - 1], 1'b0, 8'h00));
                if (pot_sel < NUM_STEPS)
                    step_note[pot_sel] = sample[7:1];
            end
            default:
            begin
                if (live)
                    burst.push_back(make_msg(1'b0, step_note[cur_step - 1], 1'b0, 8'h00));
                pot_sel = (pot_sel + 1 < NUM_STEPS) ? pot_sel + 1 : 0;
            end
        endcase

        foreach (burst[i])
        begin
            m = burst[i];
            m.last = (i == burst.size() - 1);
            expected_msgs.push_back(m);
        end
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // check messages first, then predict from the item taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_step   = '0;
            beat_count = 8'd0;
            beat_len   = TPB_RESET;
            foreach (step_note[i])
                step_note[i] = NOTE_RESET;
            step_mute  = '0;
            pot_sel    = 0;
            expected_msgs.delete();
            mismatches = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            if (msg_valid && msg_ready)
            begin
                if (expected_msgs.size() == 0)
                begin
                    $error("unexpected message: note %0d with nothing outstanding", note_number);
                    mismatches++;
                end
                else
                begin
                    head = expected_msgs.pop_front();
                    compare_field("note_on", head.body.note_on, note_on);
                    compare_field("note_number", head.body.note_number, note_number);
                    compare_field("led_update", head.body.led_update, led_update);
                    compare_field("led_pattern", head.body.led_pattern, led_pattern);
                    compare_field("last", head.last, last);
                    checked++;
                end
            end
            if (req_valid && req_ready)
                predict_request(req_t'(req_type), button_code, pot_sample);
            if (cfg_wr_en)
                beat_len = cfg_wr_data;
            pending = expected_msgs.size();
        end
    end

endmodule

[sim/testbench.sv]
// top of the midi step sequencer testbench: stimulus, back pressure and verdict
`timescale 1ns / 1ps

module testbench;
    import msq_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 20;
    localparam int NUM_PHASES = 6;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req_type = REQ_TICK;
    logic [2:0] button_code = 3'd0;
    logic [7:0] pot_sample = 8'd0;
    logic       msg_valid;
    logic       msg_ready = 1'b0;
    logic       note_on;
    logic [6:0] note_number;
    logic       led_update;
    logic [7:0] led_pattern;
    logic       last;

    int mismatches;
    int pending;
    int checked;
    int items_sent = 0;
    int idle_cycles = 0;
    int recv_wait = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    always #5 clk = ~clk;

    midi_step_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .button_code (button_code),
        .pot_sample  (pot_sample),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .note_on     (note_on),
        .note_number (note_number),
        .led_update  (led_update),
        .led_pattern (led_pattern),
        .last        (last)
    );

    sequencer_msg_checker msg_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .button_code (button_code),
        .pot_sample  (pot_sample),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .note_on     (note_on),
        .note_number (note_number),
        .led_update  (led_update),
        .led_pattern (led_pattern),
        .last        (last),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked)
    );

    // idle cycles before the next item, none while in a calm stretch
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 17));
    endfunction

    // message side: stall a random number of cycles after every message taken
    always @(posedge clk or negedge rst_n)
    begin : recv_side
        int w;
        if (!rst_n)
        begin
            msg_ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (msg_valid && msg_ready)
        begin
            w = draw_wait(recv_calm);
            if ($urandom_range(0, 19) == 0)
                recv_calm <= ~recv_calm;
            recv_wait <= w;
            msg_ready <= (w == 0);
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            msg_ready <= (recv_wait == 1);
        end
        else
            msg_ready <= 1'b1;
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (msg_valid && msg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // present one request item and hold it until taken
    task automatic send_item(input req_t rt, input logic [2:0] code, input logic [7:0] sample);
        int gap;
        gap = draw_wait(send_calm);
        if ($urandom_range(0, 11) == 0)
            send_calm = ~send_calm;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= rt;
        button_code <= code;
        pot_sample  <= sample;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop sending, let every expected message drain, then let the block settle
    task automatic wait_until_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int     beat_plan [NUM_PHASES];
        int     items_plan [NUM_PHASES];
        int     pick;
        req_t   rt;

        beat_plan  = '{1, 255, 1, 0, 3, 2};
        items_plan = '{80, 40, 60, 40, 50, 40};
        beat_plan[NUM_PHASES - 1] = $urandom_range(4, 9);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before the first beat: notes load and pots cycle silently, with wrap of the selection
        send_item(REQ_POT, 3'd0, 8'hFF);
        send_item(REQ_SELECT, 3'd7, 8'h00);
        send_item(REQ_POT, 3'd7, 8'h00);
        repeat (7) send_item(REQ_SELECT, 3'd0, 8'hFF);
        // mute the last step, toggle the first one twice
        send_item(REQ_MUTE, 3'd0, 8'h00);
        send_item(REQ_MUTE, 3'd7, 8'hFF);
        send_item(REQ_MUTE, 3'd7, 8'h00);
        // first beat only moves to step one, then normal beats at the reset length
        repeat (12) send_item(REQ_TICK, 3'd0, 8'h00);

        // random items under several beat lengths
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_idle();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= 8'(beat_plan[p]);
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            for (int i = 0; i < items_plan[p]; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    rt = REQ_TICK;
                else if (pick < 70)
                    rt = REQ_MUTE;
                else if (pick < 85)
                    rt = REQ_POT;
                else
                    rt = REQ_SELECT;
                send_item(rt, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end
        wait_until_idle();

        $display("run covered %0d items: directed start, then random ticks, mutes, pots", items_sent);
        $display("and selects over %0d beat lengths; %0d messages compared", NUM_PHASES, checked);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[midi_step_sequencer.f]
rtl/msq_pkg.sv
rtl/msq_front.sv
rtl/msq_queue.sv
rtl/msq_back.sv
rtl/midi_step_sequencer.sv
sim/sequencer_msg_checker.sv
sim/testbench.sv
